// File: rtl/rsd_pkg.sv
// shared types and constants of the strided packbits segment decoder
package rsd_pkg;

    localparam int CFG_DATA_W = 25;
    localparam int ADDR_W     = 24;
    localparam int POS_W      = 25;
    localparam int LEN_W      = 24;

    typedef enum logic [1:0] {
        CFG_START_POSITION = 2'd0,
        CFG_OUTPUT_STRIDE  = 2'd1,
        CFG_OUTPUT_SIZE    = 2'd2,
        CFG_SEGMENT_LENGTH = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LIT_PAST_IN = 3'd1,
        ST_LIT_PAST_OUT = 3'd2,
        ST_REP_PAST_OUT = 3'd3,
        ST_REP_PAST_IN = 3'd4
    } t_status;

    localparam logic [7:0] SKIP_CONTROL = 8'h80;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_value;
        logic [7:0]        repeat_count;
        logic              last_write;
        t_status           status;
    } t_result;

endpackage

// File: rtl/rsd_front.sv
// front end: configuration registers, control byte decode and run tracking
module rsd_front #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [rsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_full,
    output logic                             o_stall,
    output logic                             o_push,
    output rsd_pkg::t_result                 o_result
);
    import rsd_pkg::*;

    localparam logic [ADDR_W-1:0] AddrMask = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [LEN_W-1:0] r_start,     n_start;
    logic [7:0]       r_stride,    n_stride;
    logic [POS_W-1:0] r_size,      n_size;
    logic [LEN_W-1:0] r_seg_len,   n_seg_len;

    t_phase           r_phase,     n_phase;
    logic [7:0]       r_lit_left,  n_lit_left;
    logic [7:0]       r_copies,    n_copies;
    logic [15:0]      r_rep_step,  n_rep_step;
    logic [POS_W-1:0] r_position,  n_position;
    logic [LEN_W-1:0] r_remaining, n_remaining;

    logic             accept;
    logic [7:0]       neg_b;
    logic [6:0]       mult_k;
    logic [14:0]      prod;
    logic [POS_W:0]   reach;
    logic             over;
    logic [LEN_W-1:0] rem_dec;
    logic [POS_W:0]   pos_lit;
    logic [POS_W:0]   pos_rep;
    logic [7:0]       lit_dec;
    logic [ADDR_W-1:0] cur_addr;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign neg_b    = ~i_data_byte + 8'd1;
    assign mult_k   = i_data_byte[7] ? neg_b[6:0] : i_data_byte[6:0];
    assign prod     = 15'(mult_k) * 15'(r_stride);
    assign reach    = {1'b0, r_position} + (POS_W+1)'(prod);
    assign over     = reach >= {1'b0, r_size};
    assign rem_dec  = r_remaining - LEN_W'(1);
    assign pos_lit  = {1'b0, r_position} + (POS_W+1)'(r_stride);
    assign pos_rep  = {1'b0, r_position} + (POS_W+1)'(r_rep_step);
    assign lit_dec  = r_lit_left - 8'd1;
    assign cur_addr = r_position[ADDR_W-1:0] & AddrMask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_stride    <= 8'd1;
            r_size      <= '0;
            r_seg_len   <= '0;
            r_phase     <= PH_CONTROL;
            r_lit_left  <= '0;
            r_copies    <= '0;
            r_rep_step  <= '0;
            r_position  <= '0;
            r_remaining <= '0;
        end else begin
            r_start     <= n_start;
            r_stride    <= n_stride;
            r_size      <= n_size;
            r_seg_len   <= n_seg_len;
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_copies    <= n_copies;
            r_rep_step  <= n_rep_step;
            r_position  <= n_position;
            r_remaining <= n_remaining;
        end
    end

    always_comb begin
        n_start     = r_start;
        n_stride    = r_stride;
        n_size      = r_size;
        n_seg_len   = r_seg_len;
        n_phase     = r_phase;
        n_lit_left  = r_lit_left;
        n_copies    = r_copies;
        n_rep_step  = r_rep_step;
        n_position  = r_position;
        n_remaining = r_remaining;
        o_push      = 1'b0;
        o_result    = '{write_address: '0, write_value: '0, repeat_count: '0,
                        last_write: 1'b1, status: ST_OK};

        if (accept) begin
            unique case (r_phase)
                PH_LITERAL: begin
                    o_push      = 1'b1;
                    n_remaining = rem_dec;
                    n_position  = pos_lit[POS_W-1:0];
                    n_lit_left  = lit_dec;
                    o_result    = '{write_address: cur_addr, write_value: i_data_byte,
                                    repeat_count: 8'd1, last_write: 1'b0, status: ST_OK};
                    if (lit_dec == 8'd0) begin
                        n_phase = PH_CONTROL;
                        o_result.last_write = (rem_dec < LEN_W'(2)) ||
                                              (pos_lit >= {1'b0, r_size});
                    end
                end
                PH_REPEAT: begin
                    o_push      = 1'b1;
                    n_remaining = rem_dec;
                    n_position  = pos_rep[POS_W-1:0];
                    n_phase     = PH_CONTROL;
                    o_result    = '{write_address: cur_addr, write_value: i_data_byte,
                                    repeat_count: r_copies,
                                    last_write: (rem_dec < LEN_W'(2)) ||
                                                (pos_rep >= {1'b0, r_size}),
                                    status: ST_OK};
                end
                PH_CONTROL: begin
                    if (r_remaining == '0 || r_position >= r_size) begin
                        o_push = 1'b1;
                    end else begin
                        n_remaining = rem_dec;
                        if (!i_data_byte[7]) begin
                            if (rem_dec <= LEN_W'(i_data_byte)) begin
                                o_push          = 1'b1;
                                o_result.status = ST_LIT_PAST_IN;
                            end else if (over) begin
                                o_push          = 1'b1;
                                o_result.status = ST_LIT_PAST_OUT;
                            end else begin
                                n_lit_left = i_data_byte + 8'd1;
                                n_phase    = PH_LITERAL;
                            end
                        end else if (i_data_byte == SKIP_CONTROL) begin
                            o_push = rem_dec < LEN_W'(2);
                        end else if (over) begin
                            o_push          = 1'b1;
                            o_result.status = ST_REP_PAST_OUT;
                        end else if (rem_dec == '0) begin
                            o_push          = 1'b1;
                            o_result.status = ST_REP_PAST_IN;
                        end else begin
                            n_copies   = neg_b + 8'd1;
                            n_rep_step = 16'(prod) + 16'(r_stride);
                            n_phase    = PH_REPEAT;
                        end
                    end
                end
                PH_DONE: begin
                    o_push = 1'b0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
            if (o_push && o_result.last_write) begin
                n_phase = PH_DONE;
            end
        end

        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_START_POSITION: n_start   = i_cfg_data[LEN_W-1:0];
                CFG_OUTPUT_STRIDE:  n_stride  = i_cfg_data[7:0];
                CFG_OUTPUT_SIZE:    n_size    = i_cfg_data[POS_W-1:0];
                CFG_SEGMENT_LENGTH: n_seg_len = i_cfg_data[LEN_W-1:0];
                default:            n_start   = r_start;
            endcase
            n_phase     = PH_CONTROL;
            n_lit_left  = '0;
            n_copies    = '0;
            n_position  = {1'b0, n_start};
            n_remaining = n_seg_len;
        end
    end

`ifndef SYNTH
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.last_write && !i_cfg_we) |=> (r_phase == PH_DONE))
        else $error("final beat did not end the segment");
    a_literal_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LITERAL) |-> (r_lit_left != 8'd0))
        else $error("literal run with no bytes left");
    a_remaining_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= r_seg_len)
        else $error("input byte count exceeds segment length");
    a_no_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !i_cfg_we) |=> (r_phase == PH_DONE || $past(i_cfg_we)))
        else $error("segment restarted without a register write");
`endif

endmodule

// File: rtl/rsd_queue.sv
// back end: two-entry result queue feeding the output channel
module rsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rsd_pkg::t_result i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output rsd_pkg::t_result o_data,
    input  logic             i_stall
);
    import rsd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;
    logic       push;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    assign push    = i_push && !o_full;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");
    a_fill_to_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && r_count == 2'd1) |=> o_full)
        else $error("queue did not fill");
`endif

endmodule

// File: rtl/rle_segment_strided_decoder.sv
// top level of the strided packbits segment decoder
// Decodes one compressed byte per cycle while the result queue is not full: the write command
// of an accepted byte is written into the output queue in the same cycle, since the decode of
// the control byte is combinational (one 7x8 multiply with a 26-bit add and compare for the
// run bound check). Results pass through a two-beat queue; the input is stalled only while
// that queue is full. Register writes are always accepted and restart the segment at the
// configured start position.
module rle_segment_strided_decoder #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [rsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rsd_pkg::ADDR_W-1:0]     o_write_address,
    output logic [7:0]                     o_write_value,
    output logic [7:0]                     o_repeat_count,
    output logic                           o_last_write,
    output logic [2:0]                     o_status
);
    import rsd_pkg::*;

    logic    push;
    logic    full;
    t_result push_data;
    t_result out_data;

    assign o_cfg_ready = 1'b1;

    rsd_front #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_result    (push_data)
    );

    rsd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (o_valid),
        .o_data      (out_data),
        .i_stall     (i_stall)
    );

    assign o_write_address = out_data.write_address;
    assign o_write_value   = out_data.write_value;
    assign o_repeat_count  = out_data.repeat_count;
    assign o_last_write    = out_data.last_write;
    assign o_status        = out_data.status;

endmodule

// File: test/rle_segment_strided_decoder_tb.sv
// self-checking testbench of the strided packbits segment decoder with a write-command predictor
`timescale 1ns / 100ps

module rle_segment_strided_decoder_tb;
    import rsd_pkg::*;

    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = CFG_START_POSITION;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_data_byte = 8'd0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [ADDR_W-1:0]     o_write_address;
    logic [7:0]            o_write_value;
    logic [7:0]            o_repeat_count;
    logic                  o_last_write;
    logic [2:0]            o_status;

    rle_segment_strided_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_repeat_count  (o_repeat_count),
        .o_last_write    (o_last_write),
        .o_status        (o_status)
    );

    always #10 i_clk = ~i_clk;

    t_result         pending_writes[$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count    = 0;
    int unsigned     tx_gap_pct     = 0;
    int unsigned     rx_stall_pct   = 0;
    int unsigned     stall_left     = 0;

    logic [23:0]     cfg_start;
    logic [7:0]      cfg_stride;
    logic [24:0]     cfg_size;
    logic [23:0]     cfg_seg_len;
    t_phase          dec_phase;
    logic [7:0]      lit_left;
    logic [7:0]      rep_copies;
    longint unsigned out_pos;
    logic [23:0]     consumed;

    function automatic int unsigned pick_idle_len();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function void restart_segment();
        dec_phase  = PH_CONTROL;
        lit_left   = 8'd0;
        rep_copies = 8'd0;
        out_pos    = 64'(cfg_start);
        consumed   = 24'd0;
    endfunction

    function void push_write(longint unsigned addr, logic [7:0] value, logic [7:0] count,
                             logic last, t_status st);
        t_result r;
        r.write_address = addr[ADDR_W-1:0];
        r.write_value   = value;
        r.repeat_count  = count;
        r.last_write    = last;
        r.status        = st;
        pending_writes.push_back(r);
        if (last) begin
            dec_phase = PH_DONE;
        end
    endfunction

    function bit segment_exhausted();
        int unsigned remaining;
        remaining = 32'(cfg_seg_len - consumed);
        return (remaining < 2) || (out_pos >= cfg_size);
    endfunction

    function void apply_register(t_cfg_reg index, logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_START_POSITION: cfg_start   = value[23:0];
            CFG_OUTPUT_STRIDE:  cfg_stride  = value[7:0];
            CFG_OUTPUT_SIZE:    cfg_size    = value;
            CFG_SEGMENT_LENGTH: cfg_seg_len = value[23:0];
        endcase
        restart_segment();
    endfunction

    function void decode_byte(logic [7:0] b);
        longint unsigned addr;
        int unsigned     remaining;
        int unsigned     run_len;
        int unsigned     copies;
        case (dec_phase)
            PH_LITERAL: begin
                addr     = out_pos;
                consumed = consumed + 24'd1;
                out_pos  = out_pos + cfg_stride;
                lit_left = lit_left - 8'd1;
                if (lit_left != 0) begin
                    push_write(addr, b, 8'd1, 1'b0, ST_OK);
                end else begin
                    dec_phase = PH_CONTROL;
                    push_write(addr, b, 8'd1, segment_exhausted(), ST_OK);
                end
            end
            PH_REPEAT: begin
                addr      = out_pos;
                consumed  = consumed + 24'd1;
                out_pos   = out_pos + longint'(rep_copies) * cfg_stride;
                dec_phase = PH_CONTROL;
                push_write(addr, b, rep_copies, segment_exhausted(), ST_OK);
            end
            PH_CONTROL: begin
                if (consumed >= cfg_seg_len || out_pos >= cfg_size) begin
                    push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_OK);
                end else begin
                    consumed  = consumed + 24'd1;
                    remaining = 32'(cfg_seg_len - consumed);
                    if (b < SKIP_CONTROL) begin
                        run_len = b + 1;
                        if (remaining < run_len) begin
                            push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_LIT_PAST_IN);
                        end else if (out_pos + longint'(run_len - 1) * cfg_stride
                                     >= cfg_size) begin
                            push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_LIT_PAST_OUT);
                        end else begin
                            lit_left  = 8'(run_len);
                            dec_phase = PH_LITERAL;
                        end
                    end else if (b == SKIP_CONTROL) begin
                        if (segment_exhausted()) begin
                            push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_OK);
                        end
                    end else begin
                        copies = 257 - b;
                        if (out_pos + longint'(copies - 1) * cfg_stride >= cfg_size) begin
                            push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_REP_PAST_OUT);
                        end else if (remaining == 0) begin
                            push_write(64'd0, 8'd0, 8'd0, 1'b1, ST_REP_PAST_IN);
                        end else begin
                            rep_copies = 8'(copies);
                            dec_phase  = PH_REPEAT;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_start   = 24'd0;
            cfg_stride  = 8'd1;
            cfg_size    = 25'd0;
            cfg_seg_len = 24'd0;
            restart_segment();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(t_cfg_reg'(i_cfg_index), i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                decode_byte(i_data_byte);
            end
        end
    end

    always @(posedge i_clk) begin : check_writes
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_writes.size() == 0) begin
                $error("write command with none pending: address %0h value %0h count %0d",
                       o_write_address, o_write_value, o_repeat_count);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                if (want.write_address !== o_write_address) begin
                    $error("write_address: expected %0h, got %0h",
                           want.write_address, o_write_address);
                    mismatch_count++;
                end
                if (want.write_value !== o_write_value) begin
                    $error("write_value: expected %0h, got %0h", want.write_value, o_write_value);
                    mismatch_count++;
                end
                if (want.repeat_count !== o_repeat_count) begin
                    $error("repeat_count: expected %0d, got %0d",
                           want.repeat_count, o_repeat_count);
                    mismatch_count++;
                end
                if (want.last_write !== o_last_write) begin
                    $error("last_write: expected %0b, got %0b", want.last_write, o_last_write);
                    mismatch_count++;
                end
                if (want.status !== o_status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            stall_left = pick_idle_len();
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg index, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_segment(input logic [23:0] start, input logic [7:0] stride,
                               input logic [24:0] out_size, input logic [23:0] seg_len);
        wait_idle();
        write_register(CFG_START_POSITION, {1'b0, start});
        write_register(CFG_OUTPUT_STRIDE, 25'(stride));
        write_register(CFG_OUTPUT_SIZE, out_size);
        write_register(CFG_SEGMENT_LENGTH, {1'b0, seg_len});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_byte(8'h00);
        send_byte(8'h05);
    endtask

    task automatic test_runs();
        set_segment(24'd100, 8'd3, 25'd5000, 24'd10);
        send_byte(8'h01);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(SKIP_CONTROL);
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h12);
    endtask

    task automatic test_error_status();
        set_segment(24'd0, 8'd1, 25'd1000, 24'd3);
        send_byte(8'h05);
        set_segment(24'd0, 8'd1, 25'd4, 24'd50);
        send_byte(8'h7F);
        set_segment(24'd10, 8'd2, 25'd12, 24'd50);
        send_byte(8'hFE);
        set_segment(24'd0, 8'd1, 25'd1000, 24'd1);
        send_byte(8'hFF);
    endtask

    task automatic test_empty_endings();
        set_segment(24'd0, 8'd1, 25'd1000, 24'd2);
        send_byte(SKIP_CONTROL);
        set_segment(24'd50, 8'd1, 25'd50, 24'd10);
        send_byte(8'h00);
    endtask

    task automatic test_extreme_settings();
        set_segment(24'hFFFFFF, 8'd255, 25'h1000000, 24'hFFFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        set_segment(24'd7, 8'd0, 25'd8, 24'd6);
        send_byte(8'h81);
        send_byte(8'h33);
        send_byte(8'h01);
        send_byte(8'h44);
        send_byte(8'h45);
    endtask

    task automatic test_random_segments();
        logic [7:0]      seg_bytes[$];
        longint unsigned start;
        longint unsigned out_size;
        int unsigned     stride;
        int unsigned     seg_len;
        int unsigned     left;
        int unsigned     run_len;
        int unsigned     len_max;
        int unsigned     copies;
        int unsigned     pick;
        int unsigned     body;
        int unsigned     sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_gap_pct   = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(10, 50);
            rx_stall_pct = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(10, 50);

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                stride = 0;
            end else if (pick < 10) begin
                stride = 255;
            end else if (pick < 70) begin
                stride = $urandom_range(1, 4);
            end else begin
                stride = $urandom_range(0, 255);
            end

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                seg_len = 0;
            end else if (pick < 10) begin
                seg_len = 1;
            end else if (pick < 80) begin
                seg_len = $urandom_range(2, 40);
            end else begin
                seg_len = $urandom_range(41, 200);
            end

            start = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 24'hFFFFFF)
                                                 : $urandom_range(0, 1000);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                out_size = start - $urandom_range(0, start < 3 ? start : 3);
            end else if (pick < 30) begin
                out_size = start + $urandom_range(1, 300);
            end else if (pick < 40) begin
                out_size = 25'h1000000;
            end else begin
                out_size = start + 100000;
            end
            if (out_size > 25'h1000000) begin
                out_size = 25'h1000000;
            end

            seg_bytes.delete();
            if ($urandom_range(0, 99) < 85) begin
                left = seg_len;
                while (left > 0) begin
                    pick = $urandom_range(0, 99);
                    if (left == 1) begin
                        seg_bytes.push_back(8'($urandom_range(0, 255)));
                        left = 0;
                    end else if (pick < 45) begin
                        len_max = (left - 1 < 128) ? left - 1 : 128;
                        run_len = ($urandom_range(0, 99) < 80)
                                  ? $urandom_range(1, len_max < 8 ? len_max : 8)
                                  : $urandom_range(1, len_max);
                        seg_bytes.push_back(8'(run_len - 1));
                        repeat (run_len) seg_bytes.push_back(8'($urandom_range(0, 255)));
                        left -= run_len + 1;
                    end else if (pick < 85) begin
                        copies = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 8)
                                                              : $urandom_range(2, 128);
                        seg_bytes.push_back(8'(257 - copies));
                        seg_bytes.push_back(8'($urandom_range(0, 255)));
                        left -= 2;
                    end else begin
                        seg_bytes.push_back(SKIP_CONTROL);
                        left -= 1;
                    end
                end
            end else begin
                repeat ((seg_len < 60 ? seg_len : 60) + $urandom_range(0, 3)) begin
                    seg_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            body = seg_bytes.size();
            repeat ($urandom_range(0, 3)) seg_bytes.push_back(8'($urandom_range(0, 255)));

            set_segment(24'(start), 8'(stride), 25'(out_size), 24'(seg_len));
            foreach (seg_bytes[k]) begin
                send_byte(seg_bytes[k]);
            end
            sent += body;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        test_reset_state();
        test_runs();
        test_error_status();
        test_empty_endings();
        test_extreme_settings();
        test_random_segments();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
